### design/fpst_pkg.sv
// Package for the Fenwick prefix sum table: working widths, operation codes,
// the shared adder request type and the helper used by the sequencer.
// No dependencies.
`default_nettype none

package fpst_pkg;

  // Default number of tree entries in the store
  localparam int unsigned DepthDef = 1024;

  // Width of the active size register
  localparam int unsigned CfgW = 11;

  // Working index width: covers the size in use and idx | (idx + 1)
  localparam int unsigned IW = CfgW + 1;

  // Width of a bit position within a working index
  localparam int unsigned KW = $clog2(IW);

  // Operation codes carried by func_i
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_PREFIX = 2'd1;
  localparam logic [1:0] FUNC_RANGE  = 2'd2;
  localparam logic [1:0] FUNC_SEARCH = 2'd3;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  // Position of the highest set bit; zero for a zero word
  function automatic logic [KW-1:0] floor_log2(input logic [IW-1:0] v);
    logic [KW-1:0] r;
    r = '0;
    for (int i = 0; i < IW; i++) begin
      if (v[i]) r = KW'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/fpst_alu.sv
// Shared 32-bit add/subtract unit with a signed less-than compare.
// Depends on fpst_pkg for the request type.
`default_nettype none

module fpst_alu (
  input  fpst_pkg::alu_req_t req_i,
  output logic [31:0]        res_o,
  output logic               b_lt_a_o
);
  import fpst_pkg::*;

  always_comb begin
    case (req_i.op)
      ALU_ADD: res_o = req_i.a + req_i.b;
      ALU_SUB: res_o = req_i.a - req_i.b;
      default: res_o = req_i.a + req_i.b;
    endcase
  end

  assign b_lt_a_o = $signed(req_i.b) < $signed(req_i.a);

endmodule

`default_nettype wire

### design/fpst_mem.sv
// Tree store: one write port, one read port, registered read data.
// No package dependencies.
`default_nettype none

module fpst_mem #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### design/fpst_ctrl.sv
// Sequencer for the Fenwick table: clearing pass, tree walks for add, prefix,
// range and search, all through one shared adder. Uses fpst_pkg and fpst_alu.
`default_nettype none

module fpst_ctrl #(
  parameter int unsigned DEPTH = fpst_pkg::DepthDef,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [fpst_pkg::CfgW-1:0] active_size_i,
  input  logic                      start_i,
  input  logic [1:0]                func_i,
  input  logic [9:0]                index_i,
  input  logic [9:0]                index_low_i,
  input  logic signed [31:0]        value_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic signed [31:0]        sum_value_o,
  output logic [fpst_pkg::CfgW-1:0] found_index_o,
  output logic                      we_o,
  output logic [AW-1:0]             waddr_o,
  output logic [31:0]               wdata_o,
  output logic [AW-1:0]             raddr_o,
  input  logic [31:0]               rdata_i
);
  import fpst_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EX,
    S_FIN
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [1:0]    func_q, func_d;
  logic [IW-1:0] n_q, n_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] lo_q, lo_d;
  logic [IW-1:0] pre_q, pre_d;
  logic [KW-1:0] k_q, k_d;
  logic          phase_q, phase_d;
  logic [31:0]   val_q, val_d;
  logic [31:0]   acc_q, acc_d;
  logic          done_q, done_d;
  logic [31:0]   sum_q, sum_d;
  logic [CfgW-1:0] found_q, found_d;

  logic [IW-1:0] n_start;
  logic [IW-1:0] hi_in;
  logic [IW-1:0] ask;
  logic [IW-1:0] bit_k;
  logic [IW-1:0] parent;
  logic [IW-1:0] lo_m1;
  logic [IW-1:0] up_next;
  logic [IW-1:0] rd_addr;

  alu_req_t      alu_req;
  logic [31:0]   alu_res;
  logic          alu_lt;

  fpst_alu u_alu (
    .req_i    (alu_req),
    .res_o    (alu_res),
    .b_lt_a_o (alu_lt)
  );

  // Size in use: clamp the register to 1..DEPTH
  always_comb begin
    if (active_size_i == '0) begin
      n_start = IW'(1);
    end else if (32'(active_size_i) > 32'(DEPTH)) begin
      n_start = IW'(DEPTH);
    end else begin
      n_start = IW'(active_size_i);
    end
  end

  assign hi_in   = IW'(index_i);
  assign bit_k   = IW'(1) << k_q;
  assign ask     = pre_q + bit_k - IW'(1);
  assign parent  = idx_q & (idx_q + IW'(1));
  assign up_next = idx_q | (idx_q + IW'(1));
  assign lo_m1   = lo_q - IW'(1);
  assign rd_addr = (func_q == FUNC_SEARCH) ? ask : idx_q;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    func_d  = func_q;
    n_d     = n_q;
    idx_d   = idx_q;
    lo_d    = lo_q;
    pre_d   = pre_q;
    k_d     = k_q;
    phase_d = phase_q;
    val_d   = val_q;
    acc_d   = acc_q;
    done_d  = 1'b0;
    sum_d   = sum_q;
    found_d = found_q;

    we_o    = 1'b0;
    waddr_o = AW'(idx_q);
    wdata_o = alu_res;
    raddr_o = AW'(rd_addr);

    alu_req.op = ALU_ADD;
    alu_req.a  = acc_q;
    alu_req.b  = rdata_i;

    case (state_q)
      S_CLEAR: begin
        we_o    = 1'b1;
        waddr_o = clr_q;
        wdata_o = '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (start_i) begin
          func_d  = func_i;
          n_d     = n_start;
          val_d   = value_i;
          acc_d   = '0;
          pre_d   = '0;
          phase_d = 1'b0;
          lo_d    = IW'(index_low_i);
          k_d     = floor_log2(n_start);
          state_d = S_RD;
          if (func_i == FUNC_ADD) begin
            idx_d = hi_in;
            if (hi_in >= n_start) state_d = S_FIN;
          end else begin
            // saturate the upper end to the last entry in use
            idx_d = (hi_in >= n_start) ? n_start - IW'(1) : hi_in;
          end
        end
      end

      S_RD: begin
        state_d = S_EX;
        if (func_q == FUNC_SEARCH && ask >= n_q) begin
          // node beyond the size: skip this bit
          if (k_q == '0) begin
            state_d = S_FIN;
          end else begin
            k_d     = k_q - KW'(1);
            state_d = S_RD;
          end
        end
      end

      S_EX: begin
        case (func_q)
          FUNC_ADD: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = rdata_i;
            alu_req.b  = val_q;
            we_o       = 1'b1;
            if (up_next < n_q) begin
              idx_d   = up_next;
              state_d = S_RD;
            end else begin
              state_d = S_FIN;
            end
          end
          FUNC_SEARCH: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = val_q;
            alu_req.b  = rdata_i;
            if (alu_lt) begin
              val_d = alu_res;
              pre_d = pre_q | bit_k;
            end
            if (k_q == '0) begin
              state_d = S_FIN;
            end else begin
              k_d     = k_q - KW'(1);
              state_d = S_RD;
            end
          end
          default: begin
            // prefix walk; the lower walk of a range subtracts
            alu_req.op = phase_q ? ALU_SUB : ALU_ADD;
            alu_req.a  = acc_q;
            alu_req.b  = rdata_i;
            acc_d      = alu_res;
            if (parent == '0) begin
              if (func_q == FUNC_RANGE && !phase_q && lo_q != '0) begin
                phase_d = 1'b1;
                idx_d   = (lo_m1 >= n_q) ? n_q - IW'(1) : lo_m1;
                state_d = S_RD;
              end else begin
                state_d = S_FIN;
              end
            end else begin
              idx_d   = parent - IW'(1);
              state_d = S_RD;
            end
          end
        endcase
      end

      S_FIN: begin
        done_d  = 1'b1;
        sum_d   = (func_q == FUNC_PREFIX || func_q == FUNC_RANGE) ? acc_q : '0;
        found_d = (func_q == FUNC_SEARCH) ? CfgW'(pre_q) : '0;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
      func_q  <= FUNC_ADD;
      phase_q <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      func_q  <= func_d;
      phase_q <= phase_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    idx_q   <= idx_d;
    lo_q    <= lo_d;
    pre_q   <= pre_d;
    val_q   <= val_d;
    acc_q   <= acc_d;
    sum_q   <= sum_d;
    found_q <= found_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign sum_value_o   = sum_q;
  assign found_index_o = found_q;

endmodule

`default_nettype wire

### design/fenwick_prefix_sum_table.sv
// Top level of the Fenwick prefix sum table: size register, tree store and
// sequencer. Depends on fpst_pkg, fpst_mem and fpst_ctrl.
//
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+------------------------
//  command   | func_i, index_i, index_low_i, value_i          | start_i && !busy_o
//  result    | sum_value_o, found_index_o                     | done_o, one cycle
//  config    | cfg_data_i (active size)                       | cfg_valid_i && cfg_ready_o
//
// Each tree node visited takes the registered store read, then a pass through the
// shared adder. Search skips the adder step for a bit whose node lies beyond the size.
// A new command is taken in the strobe cycle. After reset a clearing pass that writes
// zero to every entry holds busy_o high. Results cannot be stalled.
`default_nettype none

module fenwick_prefix_sum_table #(
  parameter int unsigned DEPTH = fpst_pkg::DepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                func_i,
  input  logic [9:0]                index_i,
  input  logic [9:0]                index_low_i,
  input  logic signed [31:0]        value_i,
  output logic                      done_o,
  output logic signed [31:0]        sum_value_o,
  output logic [fpst_pkg::CfgW-1:0] found_index_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [fpst_pkg::CfgW-1:0] cfg_data_i
);
  import fpst_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [CfgW-1:0] size_q;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [31:0]     wdata;
  logic [AW-1:0]   raddr;
  logic [31:0]     rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= CfgW'(1024);
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= cfg_data_i;
    end
  end

  fpst_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  fpst_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .active_size_i (size_q),
    .start_i       (start_i),
    .func_i        (func_i),
    .index_i       (index_i),
    .index_low_i   (index_low_i),
    .value_i       (value_i),
    .busy_o        (busy_o),
    .done_o        (done_o),
    .sum_value_o   (sum_value_o),
    .found_index_o (found_index_o),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .raddr_o       (raddr),
    .rdata_i       (rdata)
  );

endmodule

`default_nettype wire

### design/fpst_checker.sv
// Port-level checks for the Fenwick prefix sum table, bound to the top level.
// Depends on fpst_pkg for the size register width.
`default_nettype none

module fpst_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic                      done_o,
  input logic signed [31:0]        sum_value_o,
  input logic [fpst_pkg::CfgW-1:0] found_index_o
);

  // An accepted transaction keeps the block busy in the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not raise busy");

  // One result per transaction: no back-to-back strobes
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

  // A result is shown only once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // A sum and a search index never come in the same result
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (sum_value_o == 0 || found_index_o == 0))
    else $error("result carries both a sum and an index");

endmodule

bind fenwick_prefix_sum_table fpst_checker u_fpst_checker (.*);

`default_nettype wire
